FILE: rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the odometry block
// Fixed-point constants, arctangent table and divider status.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam logic [31:0] MPC_RESET = 32'd4249776;
   localparam logic [23:0] IHW_RESET = 24'd504123;

   localparam logic signed [19:0] PI_Q16      = 20'sd205887;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102943;
   localparam logic signed [19:0] TWO_PI_Q16  = 20'sd411774;

   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
   localparam logic [31:0] US_PER_S        = 32'd1000000;

   localparam int ANGLE_ITERATIONS_DEF = 16;

   // datapath widths
   localparam int ACC_W     = 64;
   localparam int MPLR_W    = 32;
   localparam int DIST_W    = 34;
   localparam int DTH_W     = 42;
   localparam int XV_W      = 52;
   localparam int Z_W       = 34;
   localparam int DIV_W     = 62;
   localparam int DIV_DEN_W = 24;

   // csr indexes
   localparam logic CSR_MPC = 1'b0;
   localparam logic CSR_IHW = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // arctan(2^-i) in Q2.30, truncated
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/ddo_if.sv
// ----------------------------------------------------------------------------
// ddo_req_if / ddo_rsp_if: valid/ready channels of the odometry block
// Request carries encoder deltas and elapsed time; response the pose word.
// ----------------------------------------------------------------------------
interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] right_count;
   logic signed [15:0] left_count;
   logic        [23:0] elapsed_us;

   modport source(output valid, right_count, left_count, elapsed_us, input ready);
   modport sink(input valid, right_count, left_count, elapsed_us, output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [18:0] yaw;
   logic signed [31:0] lin_vel;
   logic signed [31:0] ang_vel;
   logic               time_fault;

   modport source(output valid, pos_x, pos_y, yaw, lin_vel, ang_vel, time_fault,
                  input ready);
   modport sink(input valid, pos_x, pos_y, yaw, lin_vel, ang_vel, time_fault,
                output ready);
endinterface

FILE: rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div: bit-serial restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output div_status_type       status,
   output logic [DIV_W-1:0]     quot,
   output logic [DIV_DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W+1:0] diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quot_ff[DIV_W-1]};
      diff    = {1'b0, trial} - {2'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         quot_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (!diff[DIV_DEN_W+1]) begin
               rem_in  = diff[DIV_DEN_W-1:0];
               quot_in = {quot_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[DIV_DEN_W-1:0];
               quot_in = {quot_ff[DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = busy_ff && (cnt_ff == '0);
   assign quot = quot_ff;
   assign rem  = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      status.done |=> !status.done)
      else $error("divider done held for more than one cycle");

   a_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != '0 && !start) |=> busy_ff && cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("divider count slipped");

endmodule

FILE: rtl/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry: differential-drive wheel odometry, Q16.16
// Sequencer around a bit-serial multiplier, a CORDIC and a serial divider.
// ----------------------------------------------------------------------------
// One word is worked at a time. The shift-add multiplier steps through the
// significant bits of its multiplier (meters_per_count twice, the inverse
// half wheelbase, the 30-bit CORDIC gain, 1e6 twice). The CORDIC steps through
// its iterations in turn. The restoring divider serves the heading wrap, then
// both velocities; the velocity steps are skipped when elapsed_us is zero. The
// next word is taken while the last result waits in the output register.
module diff_drive_odometry import ddo_pkg::*; #(
   parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ddo_req_if.sink      req_port,
   ddo_rsp_if.source    rsp_port,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int ITERS  = (ANGLE_ITERATIONS < 1) ? 1 :
                           (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
   localparam int ITER_W = $clog2(ITERS + 1);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_MSUM   = 12'b0000_0000_0010,
      S_MDIF   = 12'b0000_0000_0100,
      S_MTH    = 12'b0000_0000_1000,
      S_MGAIN  = 12'b0000_0001_0000,
      S_CORDIC = 12'b0000_0010_0000,
      S_WRAP   = 12'b0000_0100_0000,
      S_MLV    = 12'b0000_1000_0000,
      S_DLV    = 12'b0001_0000_0000,
      S_MAV    = 12'b0010_0000_0000,
      S_DAV    = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]               mpc_ff, mpc_in;
   logic [23:0]               ihw_ff, ihw_in;
   logic signed [31:0]        x_ff, x_in;
   logic signed [31:0]        y_ff, y_in;
   logic signed [18:0]        heading_ff, heading_in;
   logic signed [16:0]        dif_ff, dif_in;
   logic [23:0]               us_ff, us_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [MPLR_W-1:0]         mplr_ff, mplr_in;
   logic signed [DIST_W-1:0]  dist_ff, dist_in;
   logic signed [DTH_W-1:0]   dth_ff, dth_in;
   logic signed [XV_W-1:0]    xv_ff, xv_in;
   logic signed [XV_W-1:0]    yv_ff, yv_in;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic                      sneg_ff, sneg_in;
   logic                      pneg_ff, pneg_in;
   logic signed [31:0]        lin_ff, lin_in;
   logic signed [31:0]        ang_hold_ff, ang_hold_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        rsp_x_ff, rsp_x_in;
   logic signed [31:0]        rsp_y_ff, rsp_y_in;
   logic signed [18:0]        rsp_yaw_ff, rsp_yaw_in;
   logic signed [31:0]        rsp_lin_ff, rsp_lin_in;
   logic signed [31:0]        rsp_ang_ff, rsp_ang_in;
   logic                      rsp_fault_ff, rsp_fault_in;

   logic                      div_start;
   logic [DIV_W-1:0]          div_dividend;
   logic [DIV_DEN_W-1:0]      div_divisor;
   div_status_type            div_st;
   logic [DIV_W-1:0]          div_quot;
   logic [DIV_DEN_W-1:0]      div_rem;

   // comb temporaries
   logic signed [16:0]        sum17;
   logic signed [ACC_W-1:0]   acc_step;
   logic                      mul_done;
   logic signed [ACC_W-1:0]   rv;
   logic signed [19:0]        h20;
   logic signed [19:0]        hadj;
   logic                      vneg;
   logic signed [XV_W-1:0]    tx, ty;
   logic signed [Z_W-1:0]     atan_z;
   logic signed [42:0]        ssum;
   logic [42:0]               smag;
   logic signed [19:0]        r20;
   logic [ACC_W-1:0]          pmag;

   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                   input int unsigned n);
      logic signed [ACC_W-1:0] half_lsb;
      half_lsb = $signed(ACC_W'(1)) <<< (n - 1);
      return (v + half_lsb) >>> n;
   endfunction

   // truncated quotient with sign, saturated to 32 bits
   function automatic logic signed [31:0] sat_vel(input logic [DIV_W-1:0] q,
                                                  input logic neg);
      logic signed [31:0] v;
      if (!neg) begin
         v = (q[DIV_W-1:31] != '0) ? 32'sh7FFFFFFF : $signed(q[31:0]);
      end else begin
         v = (q > DIV_W'(64'd2147483648)) ? 32'sh80000000 : $signed(~q[31:0] + 32'd1);
      end
      return v;
   endfunction

   ddo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_st),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      mpc_in       = mpc_ff;
      ihw_in       = ihw_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      heading_in   = heading_ff;
      dif_in       = dif_ff;
      us_in        = us_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplr_in      = mplr_ff;
      dist_in      = dist_ff;
      dth_in       = dth_ff;
      xv_in        = xv_ff;
      yv_in        = yv_ff;
      z_in         = z_ff;
      iter_in      = iter_ff;
      sneg_in      = sneg_ff;
      pneg_in      = pneg_ff;
      lin_in       = lin_ff;
      ang_hold_in  = ang_hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_ang_in   = rsp_ang_ff;
      rsp_fault_in = rsp_fault_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      sum17    = {req_port.right_count[15], req_port.right_count}
               + {req_port.left_count[15], req_port.left_count};
      acc_step = acc_ff + (mplr_ff[0] ? mcand_ff : '0);
      mul_done = (mplr_ff == '0);
      rv       = '0;
      h20      = 20'(heading_ff);
      hadj     = h20;
      vneg     = 1'b0;
      tx       = xv_ff >>> iter_ff;
      ty       = yv_ff >>> iter_ff;
      atan_z   = $signed(Z_W'(atan_q30(5'(iter_ff))));
      ssum     = 43'(heading_ff) + 43'(dth_ff);
      smag     = ssum[42] ? 43'(-ssum) : 43'(ssum);
      r20      = $signed({1'b0, div_rem[18:0]});
      pmag     = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      // shift-add multiplier, one multiplier bit a cycle
      if ((state_ff == S_MSUM || state_ff == S_MDIF || state_ff == S_MTH ||
           state_ff == S_MGAIN || state_ff == S_MLV || state_ff == S_MAV) && !mul_done) begin
         acc_in   = acc_step;
         mcand_in = mcand_ff <<< 1;
         mplr_in  = mplr_ff >> 1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               dif_in   = {req_port.right_count[15], req_port.right_count}
                        - {req_port.left_count[15], req_port.left_count};
               us_in    = req_port.elapsed_us;
               acc_in   = '0;
               mcand_in = ACC_W'(sum17);
               mplr_in  = mpc_ff;
               state_in = S_MSUM;
            end
         end
         S_MSUM: begin
            if (mul_done) begin
               rv       = rnd(acc_ff, 17);
               dist_in  = rv[DIST_W-1:0];
               acc_in   = '0;
               mcand_in = ACC_W'(dif_ff);
               mplr_in  = mpc_ff;
               state_in = S_MDIF;
            end
         end
         S_MDIF: begin
            if (mul_done) begin
               acc_in   = '0;
               mcand_in = rnd(acc_ff, 17);
               mplr_in  = MPLR_W'(ihw_ff);
               state_in = S_MTH;
            end
         end
         S_MTH: begin
            if (mul_done) begin
               rv       = rnd(acc_ff, 16);
               dth_in   = rv[DTH_W-1:0];
               acc_in   = '0;
               mcand_in = ACC_W'(dist_ff);
               mplr_in  = CORDIC_GAIN_Q30;
               state_in = S_MGAIN;
            end
         end
         S_MGAIN: begin
            if (mul_done) begin
               // fold the heading into the right half plane, flip the vector
               if (h20 > HALF_PI_Q16) begin
                  hadj = h20 - PI_Q16;
                  vneg = 1'b1;
               end else if (h20 < -HALF_PI_Q16) begin
                  hadj = h20 + PI_Q16;
                  vneg = 1'b1;
               end
               rv       = rnd(acc_ff, 14);
               xv_in    = vneg ? -rv[XV_W-1:0] : rv[XV_W-1:0];
               yv_in    = '0;
               z_in     = Z_W'(hadj) <<< 14;
               iter_in  = '0;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (iter_ff != ITER_W'(ITERS)) begin
               if (!z_ff[Z_W-1]) begin
                  xv_in = xv_ff - ty;
                  yv_in = yv_ff + tx;
                  z_in  = z_ff - atan_z;
               end else begin
                  xv_in = xv_ff + ty;
                  yv_in = yv_ff - tx;
                  z_in  = z_ff + atan_z;
               end
               iter_in = iter_ff + 1'b1;
            end else begin
               rv           = rnd(ACC_W'(xv_ff), 16);
               x_in         = x_ff + rv[31:0];
               rv           = rnd(ACC_W'(yv_ff), 16);
               y_in         = y_ff + rv[31:0];
               sneg_in      = ssum[42];
               div_start    = 1'b1;
               div_dividend = DIV_W'(smag);
               div_divisor  = DIV_DEN_W'(TWO_PI_Q16);
               state_in     = S_WRAP;
            end
         end
         S_WRAP: begin
            if (div_st.done) begin
               if (sneg_ff && r20 != '0) begin
                  r20 = TWO_PI_Q16 - r20;
               end
               if (r20 > PI_Q16) begin
                  r20 = r20 - TWO_PI_Q16;
               end
               heading_in = r20[18:0];
               if (us_ff == '0) begin
                  lin_in   = '0;
                  state_in = S_DONE;
               end else begin
                  acc_in   = '0;
                  mcand_in = ACC_W'(dist_ff);
                  mplr_in  = US_PER_S;
                  state_in = S_MLV;
               end
            end
         end
         S_MLV, S_MAV: begin
            if (mul_done) begin
               pneg_in      = acc_ff[ACC_W-1];
               div_start    = 1'b1;
               div_dividend = pmag[DIV_W-1:0];
               div_divisor  = us_ff;
               state_in     = (state_ff == S_MLV) ? S_DLV : S_DAV;
            end
         end
         S_DLV: begin
            if (div_st.done) begin
               lin_in   = sat_vel(div_quot, pneg_ff);
               acc_in   = '0;
               mcand_in = ACC_W'(dth_ff);
               mplr_in  = US_PER_S;
               state_in = S_MAV;
            end
         end
         S_DAV: begin
            // held aside: the previous word may still wait in the output
            if (div_st.done) begin
               ang_hold_in = sat_vel(div_quot, pneg_ff);
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_yaw_in   = heading_ff;
               rsp_lin_in   = (us_ff == '0) ? '0 : lin_ff;
               rsp_ang_in   = (us_ff == '0) ? '0 : ang_hold_ff;
               rsp_fault_in = (us_ff == '0);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_MPC: mpc_in = csr_wdata;
            CSR_IHW: ihw_in = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mpc_ff       <= MPC_RESET;
         ihw_ff       <= IHW_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mpc_ff       <= mpc_in;
         ihw_ff       <= ihw_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dif_ff       <= dif_in;
      us_ff        <= us_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplr_ff      <= mplr_in;
      dist_ff      <= dist_in;
      dth_ff       <= dth_in;
      xv_ff        <= xv_in;
      yv_ff        <= yv_in;
      z_ff         <= z_in;
      iter_ff      <= iter_in;
      sneg_ff      <= sneg_in;
      pneg_ff      <= pneg_in;
      lin_ff       <= lin_in;
      ang_hold_ff  <= ang_hold_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_lin_ff   <= rsp_lin_in;
      rsp_ang_ff   <= rsp_ang_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign req_port.ready      = (state_ff == S_IDLE);
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.pos_x      = rsp_x_ff;
   assign rsp_port.pos_y      = rsp_y_ff;
   assign rsp_port.yaw        = rsp_yaw_ff;
   assign rsp_port.lin_vel    = rsp_lin_ff;
   assign rsp_port.ang_vel    = rsp_ang_ff;
   assign rsp_port.time_fault = rsp_fault_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      (20'(heading_ff) > -PI_Q16) && (20'(heading_ff) <= PI_Q16))
      else $error("heading left the wrapped range");

   a_fault_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff) |-> (rsp_lin_ff == '0 && rsp_ang_ff == '0))
      else $error("velocity not zero on time fault");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == S_WRAP || state_ff == S_DLV || state_ff == S_DAV))
      else $error("divider finished outside a division step");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CORDIC) |=> $stable(x_ff) && $stable(y_ff))
      else $error("position moved outside the CORDIC step");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for diff_drive_odometry
// Drives encoder words through several scale/wheelbase settings, predicts each
// pose word in the bench and compares it field by field with the block.
// ----------------------------------------------------------------------------
module tb import ddo_pkg::*; ();

   typedef struct {
      logic signed [15:0] right_count;
      logic signed [15:0] left_count;
      logic        [23:0] elapsed_us;
   } enc_word_type;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [18:0] yaw;
      logic signed [31:0] lin_vel;
      logic signed [31:0] ang_vel;
      logic               time_fault;
   } pose_word_type;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   ddo_req_if req_ch();
   ddo_rsp_if rsp_ch();

   diff_drive_odometry dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bench copy of registers and pose state
   logic [31:0]        scale_mpc;
   logic [23:0]        scale_ihw;
   logic [31:0]        track_x;
   logic [31:0]        track_y;
   logic signed [18:0] track_heading;

   enc_word_type  enc_queue[$];
   pose_word_type pose_expected[$];
   enc_word_type  enc_cur;
   int            cycle_cnt;
   int            err_cnt;
   int            words_out;
   int            faults_out;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic logic [31:0] rate_of(longint q, logic [23:0] us);
      longint v;
      if (us == 0) return 32'd0;
      v = (q * 1000000) / longint'(us);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic pose_word_type advance_pose(enc_word_type w);
      pose_word_type p;
      longint rc, lc, mpc, travel, half, dth, h, z, xv, yv, tx, ty, nh;
      int     iters;
      rc     = w.right_count;
      lc     = w.left_count;
      mpc    = longint'(scale_mpc);
      travel = round_shift((rc + lc) * mpc, 17);
      half   = round_shift((rc - lc) * mpc, 17);
      dth    = round_shift(half * longint'(scale_ihw), 16);
      iters  = ANGLE_ITERATIONS_DEF;
      if (iters < 1) iters = 1;
      if (iters > 24) iters = 24;
      h  = track_heading;
      xv = round_shift(travel * longint'(CORDIC_GAIN_Q30), 14);
      // fold heading into the right half plane, flip the vector to match
      if (h > longint'(HALF_PI_Q16)) begin
         h  = h - longint'(PI_Q16);
         xv = -xv;
      end else if (h < -longint'(HALF_PI_Q16)) begin
         h  = h + longint'(PI_Q16);
         xv = -xv;
      end
      z  = h * 16384;
      yv = 0;
      for (int i = 0; i < iters; i++) begin
         tx = xv >>> i;
         ty = yv >>> i;
         if (z >= 0) begin
            xv = xv - ty; yv = yv + tx; z = z - longint'(atan_q30(5'(i)));
         end else begin
            xv = xv + ty; yv = yv - tx; z = z + longint'(atan_q30(5'(i)));
         end
      end
      track_x = track_x + 32'(round_shift(xv, 16));
      track_y = track_y + 32'(round_shift(yv, 16));
      nh = (longint'(track_heading) + dth) % longint'(TWO_PI_Q16);
      if (nh < 0) nh = nh + longint'(TWO_PI_Q16);
      if (nh > longint'(PI_Q16)) nh = nh - longint'(TWO_PI_Q16);
      track_heading = nh[18:0];
      p.pos_x      = track_x;
      p.pos_y      = track_y;
      p.yaw        = track_heading;
      p.lin_vel    = rate_of(travel, w.elapsed_us);
      p.ang_vel    = rate_of(dth, w.elapsed_us);
      p.time_fault = (w.elapsed_us == 0);
      return p;
   endfunction

   task automatic report_mismatch(string what);
      $display("tb: mismatch at cycle %0d: %s", cycle_cnt, what);
      err_cnt++;
   endtask

   // quiet stretch with no idling on either side
   function automatic bit take_break();
      if (cycle_cnt > 4000 && cycle_cnt < 16000) return 1'b0;
      return $urandom_range(0, 99) < 35;
   endfunction

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tb: timeout");
         $display("tb: done, errors");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid && req_ch.ready) pose_expected.push_back(advance_pose(enc_cur));
         if (enc_queue.size() > 0 && !take_break()) begin
            enc_cur            = enc_queue.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.right_count <= enc_cur.right_count;
            req_ch.left_count  <= enc_cur.left_count;
            req_ch.elapsed_us  <= enc_cur.elapsed_us;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pose_word_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_out++;
            if (rsp_ch.time_fault) faults_out++;
            if (pose_expected.size() == 0) begin
               report_mismatch("pose word with nothing expected");
            end else begin
               e = pose_expected.pop_front();
               if (rsp_ch.pos_x !== e.pos_x)
                  report_mismatch($sformatf("pos_x %0d want %0d", rsp_ch.pos_x, e.pos_x));
               if (rsp_ch.pos_y !== e.pos_y)
                  report_mismatch($sformatf("pos_y %0d want %0d", rsp_ch.pos_y, e.pos_y));
               if (rsp_ch.yaw !== e.yaw)
                  report_mismatch($sformatf("yaw %0d want %0d", rsp_ch.yaw, e.yaw));
               if (rsp_ch.lin_vel !== e.lin_vel)
                  report_mismatch($sformatf("lin_vel %0d want %0d",
                                            rsp_ch.lin_vel, e.lin_vel));
               if (rsp_ch.ang_vel !== e.ang_vel)
                  report_mismatch($sformatf("ang_vel %0d want %0d",
                                            rsp_ch.ang_vel, e.ang_vel));
               if (rsp_ch.time_fault !== e.time_fault)
                  report_mismatch($sformatf("time_fault %0b want %0b",
                                            rsp_ch.time_fault, e.time_fault));
            end
         end
         rsp_ch.ready <= !take_break();
      end
   end

   task automatic write_reg(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MPC) scale_mpc = value;
      else scale_ihw = value[23:0];
   endtask

   task automatic queue_word(int r, int l, int us);
      enc_word_type w;
      w.right_count = r[15:0];
      w.left_count  = l[15:0];
      w.elapsed_us  = us[23:0];
      enc_queue.push_back(w);
   endtask

   task automatic queue_random(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 65)
            queue_word($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                       $urandom_range(500, 50000));
         else if (sel < 73)
            queue_word($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300, 0);
         else if (sel < 80)
            queue_word($urandom_range(0, 4000), -$urandom_range(0, 4000),
                       $urandom_range(1, 5000));
         else
            queue_word($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                       $urandom_range(0, 24'hFFFFFF));
      end
   endtask

   // hold until the block has returned every pose word
   task automatic drain();
      do @(posedge clock);
      while (enc_queue.size() > 0 || pose_expected.size() > 0 || req_ch.valid);
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_MPC;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.right_count = '0;
      req_ch.left_count  = '0;
      req_ch.elapsed_us  = '0;
      rsp_ch.ready       = 1'b0;
      cycle_cnt          = 0;
      err_cnt            = 0;
      words_out          = 0;
      faults_out         = 0;
      scale_mpc          = MPC_RESET;
      scale_ihw          = IHW_RESET;
      track_x            = '0;
      track_y            = '0;
      track_heading      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: field extremes, zero and full elapsed time, spins past pi
      queue_word(0, 0, 1000);
      queue_word(32767, 32767, 1);
      queue_word(-32768, -32768, 24'hFFFFFF);
      queue_word(32767, -32768, 0);
      queue_word(-32768, 32767, 1);
      queue_word(2000, -2000, 10000);
      queue_word(2000, -2000, 10000);
      queue_word(500, 500, 0);
      queue_word(-2000, 2000, 10000);
      queue_word(-2000, 2000, 10000);
      queue_word(-2000, 2000, 10000);
      queue_word(300, 300, 20000);
      queue_word(1, 0, 1);
      queue_word(0, -1, 24'hFFFFFF);
      queue_random(100);
      drain();

      write_reg(CSR_MPC, 32'hFFFFFFFF);
      write_reg(CSR_IHW, 24'hFFFFFF);
      queue_word(32767, -32768, 1);
      queue_word(-32768, -32768, 1);
      queue_word(32767, 32767, 0);
      queue_random(80);
      drain();

      write_reg(CSR_MPC, 32'd0);
      write_reg(CSR_IHW, 24'd0);
      queue_random(60);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_MPC, $urandom_range(1000000, 20000000));
         write_reg(CSR_IHW, $urandom_range(100000, 2000000));
         queue_random(90);
         drain();
      end

      write_reg(CSR_MPC, $urandom());
      write_reg(CSR_IHW, $urandom_range(0, 24'hFFFFFF));
      queue_random(60);
      drain();
      repeat (500) @(posedge clock);

      $display("tb: %0d pose words checked, %0d with time fault, over 8 register settings",
               words_out, faults_out);
      if (err_cnt == 0 && pose_expected.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/ddo_pkg.sv
rtl/ddo_if.sv
rtl/ddo_div.sv
rtl/diff_drive_odometry.sv
verif/tb.sv
